>>> sv/rti_pkg.sv
// ----------------------------------------------------------------------------
// rti_pkg
// Shared widths, types and helpers for the ray/triangle intersection pipeline.
// ----------------------------------------------------------------------------
package rti_pkg;

  localparam int FIELD_W = 63;
  localparam int COORD_BITS = 21;
  localparam int CB = COORD_BITS;
  localparam int SB = CB + 1;           // origin minus vertex
  localparam int PB = 2 * CB + 1;       // dir x e2
  localparam int QB = 2 * CB + 2;       // s x e1
  localparam int DPB = CB + QB;         // widest dot product term
  localparam int WB = DPB + 2;          // sum of three terms
  localparam int DB = 3 * CB;           // |det| magnitude
  localparam int RB = DB + 1;           // divider remainder
  localparam int THR_W = 40;
  localparam int DIST_W = 32;
  localparam int BARY_W = 17;
  localparam int QTB = DIST_W - 1;      // quotient bits per lane
  localparam int FRAC_OUT = 16;
  localparam int LOWB = QTB - FRAC_OUT; // numerator bits fed during division
  localparam int NDIV = QTB;            // divider stages
  localparam int LANES = 3;
  localparam int LANE_T = 0;
  localparam int LANE_U = 1;
  localparam int LANE_V = 2;

  localparam logic [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
  localparam logic [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

  typedef enum logic [1:0] {
    REG_PARALLEL_THRESHOLD = 2'd0,
    REG_MIN_DISTANCE       = 2'd1
  } cfg_reg_t;

  // work handed from the front end to the divider
  typedef struct packed {
    logic          rej;
    logic          tsat;
    logic          tneg;
    logic [DB-1:0] den;
    logic [WB-1:0] num_t;
    logic [WB-1:0] num_u;
    logic [WB-1:0] num_v;
  } rti_job_t;

  typedef struct packed {
    logic              hit;
    logic [DIST_W-1:0] distance;
    logic [BARY_W-1:0] bary_u;
    logic [BARY_W-1:0] bary_v;
  } rti_res_t;

  function automatic logic signed [CB-1:0] coord(input logic [FIELD_W-1:0] w, input int idx);
    return w[idx*CB +: CB];
  endfunction

endpackage

>>> sv/rti_front.sv
// ----------------------------------------------------------------------------
// rti_front
// Seven-stage front end: edge vectors, cross and dot products, sign fix-up,
// reject tests and t saturation check.
// ----------------------------------------------------------------------------
module rti_front
  import rti_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  logic [FIELD_W-1:0] ray_origin,
  input  logic [FIELD_W-1:0] ray_direction,
  input  logic [FIELD_W-1:0] vertex_zero,
  input  logic [FIELD_W-1:0] edge_one,
  input  logic [FIELD_W-1:0] edge_two,
  input  logic [THR_W-1:0]   parallel_threshold,
  output logic               out_vld,
  output rti_job_t           job
);

  logic [6:0] vld_r;

  // stage 1: unpack
  logic signed [CB-1:0] s1_dir_r [3];
  logic signed [CB-1:0] s1_e1_r  [3];
  logic signed [CB-1:0] s1_e2_r  [3];
  logic signed [SB-1:0] s1_s_r   [3];
  // stage 2: cross products, terms
  logic signed [CB-1:0]   s2_dir_r [3];
  logic signed [CB-1:0]   s2_e1_r  [3];
  logic signed [CB-1:0]   s2_e2_r  [3];
  logic signed [SB-1:0]   s2_s_r   [3];
  logic signed [2*CB-1:0] s2_pa_r  [3];
  logic signed [2*CB-1:0] s2_pb_r  [3];
  logic signed [QB-2:0]   s2_qa_r  [3];
  logic signed [QB-2:0]   s2_qb_r  [3];
  // stage 3: cross products
  logic signed [CB-1:0] s3_dir_r [3];
  logic signed [CB-1:0] s3_e1_r  [3];
  logic signed [CB-1:0] s3_e2_r  [3];
  logic signed [SB-1:0] s3_s_r   [3];
  logic signed [PB-1:0] s3_pv_r  [3];
  logic signed [QB-1:0] s3_qv_r  [3];
  // stage 4: dot product terms
  logic signed [DPB-1:0] s4_det_r [3];
  logic signed [DPB-1:0] s4_nu_r  [3];
  logic signed [DPB-1:0] s4_nv_r  [3];
  logic signed [DPB-1:0] s4_nt_r  [3];
  // stage 5: dot products
  logic signed [WB-1:0] s5_det_r, s5_nu_r, s5_nv_r, s5_nt_r;
  // stage 6: sign fix-up
  logic [DB-1:0]        s6_det_r;
  logic signed [WB-1:0] s6_nu_r, s6_nv_r;
  logic [WB-1:0]        s6_nt_r;
  logic                 s6_tneg_r;
  // stage 7: checks
  rti_job_t             s7_job_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[5:0], in_vld};
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;
    always_ff @(posedge clk) begin
      if (en) begin
        s1_dir_r[i] <= coord(ray_direction, i);
        s1_e1_r[i]  <= coord(edge_one, i);
        s1_e2_r[i]  <= coord(edge_two, i);
        s1_s_r[i]   <= SB'(coord(ray_origin, i)) - SB'(coord(vertex_zero, i));

        s2_dir_r[i] <= s1_dir_r[i];
        s2_e1_r[i]  <= s1_e1_r[i];
        s2_e2_r[i]  <= s1_e2_r[i];
        s2_s_r[i]   <= s1_s_r[i];
        s2_pa_r[i]  <= s1_dir_r[J] * s1_e2_r[K];
        s2_pb_r[i]  <= s1_dir_r[K] * s1_e2_r[J];
        s2_qa_r[i]  <= s1_s_r[J] * s1_e1_r[K];
        s2_qb_r[i]  <= s1_s_r[K] * s1_e1_r[J];

        s3_dir_r[i] <= s2_dir_r[i];
        s3_e1_r[i]  <= s2_e1_r[i];
        s3_e2_r[i]  <= s2_e2_r[i];
        s3_s_r[i]   <= s2_s_r[i];
        s3_pv_r[i]  <= PB'(s2_pa_r[i]) - PB'(s2_pb_r[i]);
        s3_qv_r[i]  <= QB'(s2_qa_r[i]) - QB'(s2_qb_r[i]);

        s4_det_r[i] <= DPB'(s3_e1_r[i]) * DPB'(s3_pv_r[i]);
        s4_nu_r[i]  <= DPB'(s3_s_r[i]) * DPB'(s3_pv_r[i]);
        s4_nv_r[i]  <= DPB'(s3_dir_r[i]) * DPB'(s3_qv_r[i]);
        s4_nt_r[i]  <= DPB'(s3_e2_r[i]) * DPB'(s3_qv_r[i]);
      end
    end
  end

  logic                 det_neg;
  logic signed [WB-1:0] det_fix;
  logic signed [WB:0]   nuv;
  logic signed [WB:0]   detw;
  logic                 rej_nxt;

  assign det_neg = s5_det_r[WB-1];
  assign det_fix = det_neg ? -s5_det_r : s5_det_r;
  assign detw    = $signed({{(WB+1-DB){1'b0}}, s6_det_r});
  assign nuv     = (WB+1)'(s6_nu_r) + (WB+1)'(s6_nv_r);

  always_comb begin
    rej_nxt = (s6_det_r == '0) || (s6_det_r < DB'(parallel_threshold)) ||
              s6_nu_r[WB-1] || ((WB+1)'(s6_nu_r) > detw) ||
              s6_nv_r[WB-1] || (nuv > detw);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_det_r <= WB'(s4_det_r[0]) + WB'(s4_det_r[1]) + WB'(s4_det_r[2]);
      s5_nu_r  <= WB'(s4_nu_r[0]) + WB'(s4_nu_r[1]) + WB'(s4_nu_r[2]);
      s5_nv_r  <= WB'(s4_nv_r[0]) + WB'(s4_nv_r[1]) + WB'(s4_nv_r[2]);
      s5_nt_r  <= WB'(s4_nt_r[0]) + WB'(s4_nt_r[1]) + WB'(s4_nt_r[2]);

      s6_det_r  <= det_fix[DB-1:0];
      s6_nu_r   <= det_neg ? -s5_nu_r : s5_nu_r;
      s6_nv_r   <= det_neg ? -s5_nv_r : s5_nv_r;
      s6_nt_r   <= s5_nt_r[WB-1] ? WB'(-s5_nt_r) : WB'(s5_nt_r);
      s6_tneg_r <= s5_nt_r[WB-1] ^ det_neg;

      s7_job_r.rej   <= rej_nxt;
      // quotient of 2^31 or more saturates
      s7_job_r.tsat  <= (WB+LOWB)'(s6_nt_r) >= (WB+LOWB)'({s6_det_r, {LOWB{1'b0}}});
      s7_job_r.tneg  <= s6_tneg_r;
      s7_job_r.den   <= s6_det_r;
      s7_job_r.num_t <= s6_nt_r;
      s7_job_r.num_u <= s6_nu_r;
      s7_job_r.num_v <= s6_nv_r;
    end
  end

  assign out_vld = vld_r[6];
  assign job     = s7_job_r;

endmodule

>>> sv/rti_div.sv
// ----------------------------------------------------------------------------
// rti_div
// Pipelined restoring divider, one quotient bit per stage for t, u and v,
// followed by quantization of t and the min-distance test.
// ----------------------------------------------------------------------------
module rti_div
  import rti_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  rti_job_t          job,
  input  logic [DIST_W-1:0] min_distance,
  output logic              out_vld,
  output rti_res_t          res
);

  logic [NDIV-1:0] vld_r;
  logic [RB-1:0]   rem_r  [NDIV][LANES];
  logic [QTB-1:0]  quo_r  [NDIV][LANES];
  logic [LOWB-1:0] low_r  [NDIV][LANES];
  logic [DB-1:0]   den_r  [NDIV];
  logic            rej_r  [NDIV];
  logic            tsat_r [NDIV];
  logic            tneg_r [NDIV];
  logic            vld_o_r;
  rti_res_t        res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      vld_o_r <= 1'b0;
    end else if (en) begin
      vld_r   <= {vld_r[NDIV-2:0], in_vld};
      vld_o_r <= vld_r[NDIV-1];
    end
  end

  for (genvar k = 0; k < NDIV; k++) begin : g_stage
    logic [DB-1:0] den_in;
    logic rej_in, tsat_in, tneg_in;
    if (k == 0) begin : g_first
      assign den_in  = job.den;
      assign rej_in  = job.rej;
      assign tsat_in = job.tsat;
      assign tneg_in = job.tneg;
    end else begin : g_next
      assign den_in  = den_r[k-1];
      assign rej_in  = rej_r[k-1];
      assign tsat_in = tsat_r[k-1];
      assign tneg_in = tneg_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[k]  <= den_in;
        rej_r[k]  <= rej_in;
        tsat_r[k] <= tsat_in;
        tneg_r[k] <= tneg_in;
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [RB-1:0]   rem_in, trial, rem_nxt;
      logic [QTB-1:0]  quo_in;
      logic [LOWB-1:0] low_in;
      logic            ge;

      if (k == 0) begin : g_first
        logic [WB-1:0] num;
        if (l == LANE_T) begin : g_t
          assign num = job.num_t;
        end else if (l == LANE_U) begin : g_u
          assign num = job.num_u;
        end else begin : g_v
          assign num = job.num_v;
        end
        assign rem_in = RB'(num >> LOWB);
        assign quo_in = '0;
        assign low_in = num[LOWB-1:0];
      end else begin : g_next
        assign rem_in = rem_r[k-1][l];
        assign quo_in = quo_r[k-1][l];
        assign low_in = low_r[k-1][l];
      end

      always_comb begin
        trial   = {rem_in[RB-2:0], low_in[LOWB-1]};
        ge      = trial >= RB'(den_in);
        rem_nxt = ge ? trial - RB'(den_in) : trial;
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k][l] <= rem_nxt;
          quo_r[k][l] <= {quo_in[QTB-2:0], ge};
          low_r[k][l] <= {low_in[LOWB-2:0], 1'b0};
        end
      end
    end
  end

  // t quantization: floor toward minus infinity, saturate
  logic [DIST_W-1:0] mag, dist_q;
  logic              inexact, hit_nxt;

  always_comb begin
    inexact = |rem_r[NDIV-1][LANE_T];
    mag     = {1'b0, quo_r[NDIV-1][LANE_T]} + DIST_W'(inexact);
    if (tsat_r[NDIV-1]) begin
      dist_q = tneg_r[NDIV-1] ? DIST_MIN : DIST_MAX;
    end else if (!tneg_r[NDIV-1]) begin
      dist_q = {1'b0, quo_r[NDIV-1][LANE_T]};
    end else begin
      dist_q = -mag;
    end
    hit_nxt = !rej_r[NDIV-1] && !($signed(dist_q) < $signed(min_distance));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r.hit      <= hit_nxt;
      res_r.distance <= hit_nxt ? dist_q : '0;
      res_r.bary_u   <= hit_nxt ? quo_r[NDIV-1][LANE_U][BARY_W-1:0] : '0;
      res_r.bary_v   <= hit_nxt ? quo_r[NDIV-1][LANE_V][BARY_W-1:0] : '0;
    end
  end

  assign out_vld = vld_o_r;
  assign res     = res_r;

endmodule

>>> sv/ray_triangle_intersection_top.sv
// ----------------------------------------------------------------------------
// ray_triangle_intersection_top
// pipeline: 7 front stages, 31 divider stages, 1 quantization stage
// throughput: one test per cycle while the skid register is empty, set by the
// one-bit-per-stage divider chain
// a one-word skid register holds the head word while out_ready is low; the pipe
// and in_ready hold until that word leaves, with no bubble on the output
// reset: synchronous active-low rst_n clears valid bits, the skid flag and config
// registers (threshold 16, min distance 0); no clearing pass
// ----------------------------------------------------------------------------
module ray_triangle_intersection_top
  import rti_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [FIELD_W-1:0] in_ray_origin,
  input  logic [FIELD_W-1:0] in_ray_direction,
  input  logic [FIELD_W-1:0] in_vertex_zero,
  input  logic [FIELD_W-1:0] in_edge_one,
  input  logic [FIELD_W-1:0] in_edge_two,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_hit,
  output logic [DIST_W-1:0]  out_distance,
  output logic [BARY_W-1:0]  out_bary_u,
  output logic [BARY_W-1:0]  out_bary_v,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [THR_W-1:0]   cfg_data
);

  logic [THR_W-1:0]  thr_r;
  logic [DIST_W-1:0] min_dist_r;
  logic              en, front_vld, pipe_vld, skid_full_r;
  rti_job_t          job;
  rti_res_t          pipe_res, skid_r, res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r      <= THR_W'(16);
      min_dist_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PARALLEL_THRESHOLD: thr_r <= cfg_data;
        REG_MIN_DISTANCE:       min_dist_r <= cfg_data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // pipe advances whenever the skid word is empty
  assign en       = !skid_full_r;
  assign in_ready = en;

  rti_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .en                 (en),
    .in_vld             (in_valid),
    .ray_origin         (in_ray_origin),
    .ray_direction      (in_ray_direction),
    .vertex_zero        (in_vertex_zero),
    .edge_one           (in_edge_one),
    .edge_two           (in_edge_two),
    .parallel_threshold (thr_r),
    .out_vld            (front_vld),
    .job                (job)
  );

  rti_div u_div (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_vld       (front_vld),
    .job          (job),
    .min_distance (min_dist_r),
    .out_vld      (pipe_vld),
    .res          (pipe_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_full_r <= 1'b0;
    end else if (skid_full_r) begin
      skid_full_r <= !out_ready;
    end else begin
      skid_full_r <= pipe_vld && !out_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full_r) begin
      skid_r <= pipe_res;
    end
  end

  assign res          = skid_full_r ? skid_r : pipe_res;
  assign out_valid    = skid_full_r || pipe_vld;
  assign out_hit      = res.hit;
  assign out_distance = res.distance;
  assign out_bary_u   = res.bary_u;
  assign out_bary_v   = res.bary_v;

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_distance == '0 && out_bary_u == '0 && out_bary_v == '0)
    else $error("miss word carries nonzero payload");

  a_bary_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> ({1'b0, out_bary_u} + {1'b0, out_bary_v}) <= (BARY_W+1)'(65536))
    else $error("barycentric sum exceeds one");

  a_min_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit && $stable(min_dist_r) |->
      !($signed(out_distance) < $signed(min_dist_r)))
    else $error("hit below min distance");

  a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    skid_full_r && !out_ready |=> skid_full_r && $stable(skid_r))
    else $error("skid word lost while stalled");

endmodule
